// File: rtl/core/alpha_blend_pixel_writer_assert.svh
// assertion macros used by the pixel writer controller
`ifndef ALPHA_BLEND_PIXEL_WRITER_ASSERT_SVH
`define ALPHA_BLEND_PIXEL_WRITER_ASSERT_SVH

// same-cycle implication
`define ABPW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ABPW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/abpw_pkg.sv
`timescale 1ns / 1ps
package abpw_pkg;

  localparam int KIND_W   = 2;
  localparam int COORD_W  = 10;
  localparam int PIX_W    = 32;
  localparam int DIM_W    = 9;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CH_W     = 8;
  localparam int NUM_CH   = 4;

  localparam logic [KIND_W-1:0] KIND_DRAW = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TRANSPARENT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_BOUNDS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'd1;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_READ,
    S_MUL,
    S_SUM,
    S_WRITE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic addr_en;
    logic rd_en;
    logic mul_en;
    logic sum_en;
    logic wr_en;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              in_bounds;
    logic              alpha_zero;
    logic              alpha_full;
  } dp_stat_t;

endpackage

// File: rtl/core/abpw_req_if.sv
`timescale 1ns / 1ps
interface abpw_req_if
  import abpw_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic        [KIND_W-1:0]   kind;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic        [PIX_W-1:0]    colour_in;

  modport source (output valid, kind, pos_x, pos_y, colour_in, input ready);
  modport sink (input valid, kind, pos_x, pos_y, colour_in, output ready);
endinterface

// File: rtl/core/abpw_rsp_if.sv
`timescale 1ns / 1ps
interface abpw_rsp_if
  import abpw_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [PIX_W-1:0]    pixel_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, pixel_out, status, input ready);
  modport sink (input valid, pixel_out, status, output ready);
endinterface

// File: rtl/core/abpw_cfg_if.sv
`timescale 1ns / 1ps
interface abpw_cfg_if
  import abpw_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/abpw_cfg_regs.sv
`timescale 1ns / 1ps
module abpw_cfg_regs
  import abpw_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  output logic             ready,
  input  logic [CFG_IDX_W-1:0] index,
  input  logic [DIM_W-1:0] data,
  output logic [DIM_W-1:0] eff_w,
  output logic [DIM_W-1:0] eff_h
);

  localparam int DIM_MAX = (1 << DIM_W) - 1;
  localparam int W_CAP_I = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
  localparam int H_CAP_I = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
  localparam logic [DIM_W-1:0] W_CAP = DIM_W'(W_CAP_I);
  localparam logic [DIM_W-1:0] H_CAP = DIM_W'(H_CAP_I);

  logic [DIM_W-1:0] canvas_width;
  logic [DIM_W-1:0] canvas_height;

  assign ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= DIM_RESET;
      canvas_height <= DIM_RESET;
    end else if (valid) begin
      unique case (index)
        REG_CANVAS_WIDTH:  canvas_width  <= data;
        REG_CANVAS_HEIGHT: canvas_height <= data;
        default: ;
      endcase
    end
  end

  // oversized canvas saturates to the store geometry
  assign eff_w = (canvas_width > W_CAP) ? W_CAP : canvas_width;
  assign eff_h = (canvas_height > H_CAP) ? H_CAP : canvas_height;

endmodule

// File: rtl/core/abpw_dp.sv
`timescale 1ns / 1ps
module abpw_dp
  import abpw_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                      clk,
  input  dp_cmd_t                   cmd,
  output dp_stat_t                  st,
  input  logic        [KIND_W-1:0]  kind,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic        [PIX_W-1:0]   colour_in,
  input  logic        [DIM_W-1:0]   eff_w,
  input  logic        [DIM_W-1:0]   eff_h,
  output logic        [PIX_W-1:0]   pixel_out,
  output logic        [STATUS_W-1:0] status
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIN_W  = 2 * DIM_W + 1;
  localparam int PROD_W = 2 * CH_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic [CH_W-1:0] CH_MAX = '1;

  logic        [KIND_W-1:0]  kind_r;
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] y_r;
  logic        [PIX_W-1:0]   col_r;
  logic        [ADDR_W-1:0]  addr_r;
  logic        [PIX_W-1:0]   rdata;
  logic        [PROD_W-1:0]  p_old [NUM_CH];
  logic        [PROD_W-1:0]  p_new [NUM_CH];
  logic        [PIX_W-1:0]   blend_r;
  logic        [PIX_W-1:0]   mem [DEPTH];

  logic [LIN_W-1:0]    lin_addr;
  logic [CH_W-1:0]     alpha;
  logic                in_bounds;
  logic [PIX_W-1:0]    wdata;
  logic [PIX_W-1:0]    blend_next;
  logic [PIX_W-1:0]    res_pix;
  logic [STATUS_W-1:0] res_status;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      x_r    <= pos_x;
      y_r    <= pos_y;
      col_r  <= colour_in;
    end
  end

  assign alpha     = col_r[PIX_W-1 -: CH_W];
  assign in_bounds = !x_r[COORD_W-1] && !y_r[COORD_W-1]
                     && (x_r[DIM_W-1:0] < eff_w) && (y_r[DIM_W-1:0] < eff_h);

  assign st.kind       = kind_r;
  assign st.in_bounds  = in_bounds;
  assign st.alpha_zero = (alpha == '0);
  assign st.alpha_full = (alpha == CH_MAX);

  // row-major linear address, always below the store depth when in bounds
  assign lin_addr = LIN_W'(y_r[DIM_W-1:0]) * LIN_W'(eff_w) + LIN_W'(x_r[DIM_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.addr_en) begin
      addr_r <= ADDR_W'(lin_addr);
    end
  end

  // single-port frame store
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      for (int i = 0; i < NUM_CH; i++) begin
        p_old[i] <= rdata[i*CH_W +: CH_W] * (CH_MAX - alpha);
        p_new[i] <= col_r[i*CH_W +: CH_W] * alpha;
      end
    end
  end

  // floor(s / 255) as (s + (s >> 8) + 1) >> 8, exact for s <= 255 * 255
  always_comb begin
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] q;
    blend_next = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      s = SUM_W'(p_old[i]) + SUM_W'(p_new[i]);
      q = s + (s >> CH_W) + SUM_W'(1);
      blend_next[i*CH_W +: CH_W] = q[CH_W +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      blend_r <= blend_next;
    end
  end

  assign wdata = ((kind_r == KIND_SET) || st.alpha_full) ? col_r : blend_r;

  always_comb begin
    res_pix    = '0;
    res_status = ST_DONE;
    unique case (kind_r) inside
      KIND_DRAW, KIND_SET, KIND_READ: begin
        if (!in_bounds) begin
          res_status = ST_OUT_OF_BOUNDS;
        end else if (kind_r == KIND_READ) begin
          res_pix = rdata;
        end else if (kind_r == KIND_SET) begin
          res_pix = col_r;
        end else if (st.alpha_zero) begin
          res_status = ST_TRANSPARENT;
        end else begin
          res_pix = wdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_out <= res_pix;
      status    <= res_status;
    end
  end

endmodule

// File: rtl/core/abpw_ctrl.sv
`timescale 1ns / 1ps
`include "alpha_blend_pixel_writer_assert.svh"
module abpw_ctrl
  import abpw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t st
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_ADDR;
      end
      S_ADDR: begin
        if (!st.in_bounds) begin
          state_next = S_FINISH;
        end else begin
          case (st.kind)
            KIND_READ: state_next = S_READ;
            KIND_SET:  state_next = S_WRITE;
            KIND_DRAW: begin
              if (st.alpha_zero) state_next = S_FINISH;
              else if (st.alpha_full) state_next = S_WRITE;
              else state_next = S_READ;
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_READ: begin
        state_next = (st.kind == KIND_READ) ? S_FINISH : S_MUL;
      end
      S_MUL:   state_next = S_SUM;
      S_SUM:   state_next = S_WRITE;
      S_WRITE: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        cmd.load = in_valid;
      end
      S_ADDR:   cmd.addr_en = 1'b1;
      S_READ:   cmd.rd_en = 1'b1;
      S_MUL:    cmd.mul_en = 1'b1;
      S_SUM:    cmd.sum_en = 1'b1;
      S_WRITE:  cmd.wr_en = 1'b1;
      S_FINISH: cmd.out_load = out_free;
      default: ;
    endcase
  end

  // result register: a finished request may wait here while the next one runs
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `ABPW_ASSERT_NEXT(a_accept_to_addr, clk, rst, in_valid && in_ready, state == S_ADDR, "accepted request did not start")
  `ABPW_ASSERT_NEXT(a_finish_loads, clk, rst, state == S_FINISH && out_free, out_valid && state == S_IDLE, "finished request not delivered")
  `ABPW_ASSERT_IMP(a_write_in_bounds, clk, rst, cmd.wr_en, st.in_bounds, "store write outside the canvas")
  `ABPW_ASSERT_IMP(a_no_write_on_read, clk, rst, cmd.wr_en, st.kind == KIND_DRAW || st.kind == KIND_SET, "store write for a read request")

endmodule

// File: rtl/core/alpha_blend_pixel_writer.sv
`timescale 1ns / 1ps
// channel  modport  payload
// req      sink     kind, pos_x, pos_y, colour_in
// rsp      source   pixel_out, status
// cfg      sink     index, data (0 canvas_width, 1 canvas_height)
//
// one request at a time: out-of-bounds, transparent and unused-kind requests skip the store,
// a raw set or an opaque draw only writes it, a read only reads it, and a blended draw does
// store read, multiply, divide by 255 and store write in turn on one memory port
// rst is synchronous; frame store contents are not cleared and need no sweep
// a result waits in the output register while the next request is accepted;
// a request that finishes while that register is still full waits for rsp.ready
module alpha_blend_pixel_writer
  import abpw_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst,
  abpw_req_if.sink          req,
  abpw_rsp_if.source        rsp,
  abpw_cfg_if.sink          cfg
);

  dp_cmd_t          cmd;
  dp_stat_t         st;
  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_h;

  abpw_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk   (clk),
    .rst   (rst),
    .valid (cfg.valid),
    .ready (cfg.ready),
    .index (cfg.index),
    .data  (cfg.data),
    .eff_w (eff_w),
    .eff_h (eff_h)
  );

  abpw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .st        (st)
  );

  abpw_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .st        (st),
    .kind      (req.kind),
    .pos_x     (req.pos_x),
    .pos_y     (req.pos_y),
    .colour_in (req.colour_in),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .pixel_out (rsp.pixel_out),
    .status    (rsp.status)
  );

endmodule

// File: bench/pixel_result_checker.sv
`timescale 1ns / 1ps
module pixel_result_checker
  import abpw_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic clk,
  input  logic rst,
  abpw_req_if  req,
  abpw_rsp_if  rsp,
  abpw_cfg_if  cfg,
  output int   mismatch_count,
  output int   pending_results
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CH_MAX      = 255;

  typedef struct packed {
    logic [PIX_W-1:0]    pixel;
    logic [STATUS_W-1:0] status;
  } pixel_result_t;

  logic [PIX_W-1:0] shadow_pixels [STORE_DEPTH];
  logic [DIM_W-1:0] canvas_w;
  logic [DIM_W-1:0] canvas_h;
  pixel_result_t    expected_pixels [$];
  pixel_result_t    oldest;
  int               mismatches = 0;

  assign mismatch_count = mismatches;

  task automatic report_mismatch(string what, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // per channel floor((under*(255-a) + over*a) / 255)
  function automatic logic [PIX_W-1:0] mix_pixels(logic [PIX_W-1:0] under,
                                                  logic [PIX_W-1:0] over, int alpha);
    logic [PIX_W-1:0] mixed;
    int o;
    int n;
    for (int c = 0; c < NUM_CH; c++) begin
      o = int'(under[c*CH_W +: CH_W]);
      n = int'(over[c*CH_W +: CH_W]);
      mixed[c*CH_W +: CH_W] = CH_W'((o * (CH_MAX - alpha) + n * alpha) / CH_MAX);
    end
    return mixed;
  endfunction

  function automatic pixel_result_t predict_pixel_op(logic [KIND_W-1:0] kind,
                                                     logic signed [COORD_W-1:0] px,
                                                     logic signed [COORD_W-1:0] py,
                                                     logic [PIX_W-1:0] colour);
    pixel_result_t r;
    int w;
    int h;
    int x;
    int y;
    logic [STORE_AW-1:0] addr;
    int alpha;
    r.pixel  = '0;
    r.status = ST_DONE;
    // oversized registers saturate to the store geometry
    w = (int'(canvas_w) > MAX_WIDTH) ? MAX_WIDTH : int'(canvas_w);
    h = (int'(canvas_h) > MAX_HEIGHT) ? MAX_HEIGHT : int'(canvas_h);
    x = int'(px);
    y = int'(py);
    if (kind != KIND_DRAW && kind != KIND_SET && kind != KIND_READ) begin
      return r;
    end
    if (x < 0 || y < 0 || x >= w || y >= h) begin
      r.status = ST_OUT_OF_BOUNDS;
      return r;
    end
    addr = STORE_AW'((y * w + x) % STORE_DEPTH);
    case (kind)
      KIND_READ: begin
        r.pixel = shadow_pixels[addr];
      end
      KIND_SET: begin
        shadow_pixels[addr] = colour;
        r.pixel = colour;
      end
      default: begin
        alpha = int'(colour[3*CH_W +: CH_W]);
        if (alpha == 0) begin
          r.status = ST_TRANSPARENT;
        end else begin
          r.pixel = (alpha == CH_MAX) ? colour : mix_pixels(shadow_pixels[addr], colour, alpha);
          shadow_pixels[addr] = r.pixel;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      canvas_w = DIM_RESET;
      canvas_h = DIM_RESET;
      expected_pixels.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_CANVAS_WIDTH) begin
          canvas_w = cfg.data;
        end else if (cfg.index == REG_CANVAS_HEIGHT) begin
          canvas_h = cfg.data;
        end
      end
      if (req.valid && req.ready) begin
        expected_pixels.push_back(predict_pixel_op(req.kind, req.pos_x, req.pos_y, req.colour_in));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected result", rsp.pixel_out, '0);
        end else begin
          oldest = expected_pixels.pop_front();
          if (rsp.pixel_out !== oldest.pixel) begin
            report_mismatch("pixel_out", rsp.pixel_out, oldest.pixel);
          end
          if (rsp.status !== oldest.status) begin
            report_mismatch("status", PIX_W'(rsp.status), PIX_W'(oldest.status));
          end
        end
      end
    end
    pending_results <= expected_pixels.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import abpw_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 5;
  localparam int MAX_WIDTH       = 256;
  localparam int MAX_HEIGHT      = 256;
  localparam int STORE_DEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int STORE_AW        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int IDLE_LIMIT      = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 16;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst;

  abpw_req_if req_ch ();
  abpw_rsp_if rsp_ch ();
  abpw_cfg_if cfg_ch ();

  int mismatch_count;
  int pending_results;
  bit hold_off_wanted = 1'b0;
  bit pixel_written [STORE_DEPTH];
  int canvas_w = int'(DIM_RESET);
  int canvas_h = int'(DIM_RESET);
  int burst_left = 0;

  alpha_blend_pixel_writer #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  pixel_result_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .cfg            (cfg_ch),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int clamp_dim(int raw, int limit);
    return (raw > limit) ? limit : raw;
  endfunction

  function automatic logic [STORE_AW-1:0] store_index(int x, int y, int w);
    return STORE_AW'((y * w + x) % STORE_DEPTH);
  endfunction

  // sender side: bursts of requests with random gaps between them
  task automatic issue_request(logic [KIND_W-1:0] kind, int x, int y, logic [PIX_W-1:0] colour);
    int w;
    int h;
    int gap;
    w = clamp_dim(canvas_w, MAX_WIDTH);
    h = clamp_dim(canvas_h, MAX_HEIGHT);
    if (x >= 0 && y >= 0 && x < w && y < h &&
        (kind == KIND_SET || (kind == KIND_DRAW && colour[3*CH_W +: CH_W] != '0))) begin
      pixel_written[store_index(x, y, w)] = 1'b1;
    end
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= kind;
    req_ch.pos_x     <= x[COORD_W-1:0];
    req_ch.pos_y     <= y[COORD_W-1:0];
    req_ch.colour_in <= colour;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic random_request();
    int w;
    int h;
    int x;
    int y;
    int pick;
    int span_x;
    int span_y;
    logic [KIND_W-1:0]         kind;
    logic [PIX_W-1:0]          colour;
    logic [CH_W-1:0]           alpha;
    logic signed [COORD_W-1:0] raw_x;
    logic signed [COORD_W-1:0] raw_y;
    w = clamp_dim(canvas_w, MAX_WIDTH);
    h = clamp_dim(canvas_h, MAX_HEIGHT);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      kind = KIND_DRAW;
    end else if (pick < 62) begin
      kind = KIND_SET;
    end else if (pick < 95) begin
      kind = KIND_READ;
    end else begin
      kind = KIND_UNUSED;
    end
    colour = $urandom();
    case ($urandom_range(0, 9))
      0:       alpha = '0;
      1, 2:    alpha = '1;
      3:       alpha = 8'd1;
      4:       alpha = 8'd254;
      default: alpha = CH_W'($urandom());
    endcase
    if (kind == KIND_DRAW) begin
      colour[3*CH_W +: CH_W] = alpha;
    end
    raw_x = COORD_W'($urandom());
    raw_y = COORD_W'($urandom());
    if (w > 0 && h > 0 && $urandom_range(0, 9) < 8) begin
      // each axis half the time stays in a small corner so pixels get reused
      span_x = ($urandom_range(0, 1) != 0) ? ((w < 6) ? w : 6) : w;
      span_y = ($urandom_range(0, 1) != 0) ? ((h < 6) ? h : 6) : h;
      x = $urandom_range(0, span_x - 1);
      y = $urandom_range(0, span_y - 1);
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          x = int'(raw_x);
          y = int'(raw_y);
        end
        1: begin
          x = w + $urandom_range(0, 511 - w);
          y = int'(raw_y);
        end
        2: begin
          x = int'(raw_x);
          y = h + $urandom_range(0, 511 - h);
        end
        default: begin
          x = int'(raw_x);
          y = -int'($urandom_range(1, 512));
        end
      endcase
    end
    // never read or blend over a pixel that holds nothing yet
    if (x >= 0 && y >= 0 && x < w && y < h && !pixel_written[store_index(x, y, w)] &&
        (kind == KIND_READ || (kind == KIND_DRAW && alpha != '0 && alpha != '1))) begin
      kind = KIND_SET;
    end
    issue_request(kind, x, y, colour);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_canvas(int w, int h);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_CANVAS_WIDTH;
    cfg_ch.data  <= w[DIM_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_CANVAS_HEIGHT;
    cfg_ch.data  <= h[DIM_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    canvas_w = w;
    canvas_h = h;
  endtask

  task automatic run_phase(int w, int h, int count, bit with_hold_off);
    settle();
    write_canvas(w, h);
    if (with_hold_off) begin
      hold_off_wanted = 1'b1;
    end
    repeat (count) random_request();
  endtask

  // receiver side: ready pattern switches between modes, plus one long hold-off
  initial begin : receiver
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      if (hold_off_wanted) begin
        hold_off_wanted = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      case (mode)
        0:       rsp_ch.ready <= 1'b1;
        1:       rsp_ch.ready <= ($urandom_range(0, 1) != 0);
        2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("testbench failed");
    $finish;
  end

  initial begin : stimulus
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.kind      <= KIND_DRAW;
    req_ch.pos_x     <= '0;
    req_ch.pos_y     <= '0;
    req_ch.colour_in <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_CANVAS_WIDTH;
    cfg_ch.data      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part on the reset canvas
    issue_request(KIND_SET, 0, 0, 32'h8040_2010);
    issue_request(KIND_READ, 0, 0, 32'h0);
    issue_request(KIND_DRAW, 0, 0, 32'h7FFF_00FF);
    issue_request(KIND_DRAW, 0, 0, 32'h01AB_CDEF);
    issue_request(KIND_DRAW, 0, 0, 32'hFE00_FF00);
    issue_request(KIND_DRAW, 0, 0, 32'hFF12_3456);
    issue_request(KIND_DRAW, 0, 0, 32'h00FF_FFFF);
    issue_request(KIND_READ, 0, 0, 32'hFFFF_FFFF);
    issue_request(KIND_SET, 255, 255, 32'hFFFF_FFFF);
    issue_request(KIND_DRAW, 255, 255, 32'h8000_0000);
    issue_request(KIND_READ, 255, 255, 32'h0);
    issue_request(KIND_DRAW, 1, 0, 32'hFF00_FF00);
    issue_request(KIND_READ, 1, 0, 32'h0);
    issue_request(KIND_DRAW, 2, 0, 32'h0000_0000);
    issue_request(KIND_READ, 256, 0, 32'h0);
    issue_request(KIND_SET, 0, 256, 32'hDEAD_BEEF);
    // bounds are tested before alpha
    issue_request(KIND_DRAW, -1, 0, 32'h00FF_FFFF);
    issue_request(KIND_DRAW, 511, 511, 32'h8012_3456);
    issue_request(KIND_READ, -512, -512, 32'h0);
    issue_request(KIND_SET, 0, -1, 32'h1234_5678);
    issue_request(KIND_UNUSED, 0, 0, 32'hFFFF_FFFF);
    issue_request(KIND_UNUSED, -512, 511, 32'h0);
    issue_request(KIND_SET, 0, 0, 32'h0);
    issue_request(KIND_DRAW, 0, 0, 32'h7FFF_FFFF);
    issue_request(KIND_READ, 0, 0, 32'h0);

    run_phase(8, 8, 140, 1'b1);
    run_phase(1, 1, 60, 1'b0);
    run_phase(256, 256, 140, 1'b0);
    run_phase(0, 5, 30, 1'b0);
    run_phase(5, 0, 30, 1'b0);
    run_phase(511, 300, 140, 1'b0);
    run_phase(3, 200, 140, 1'b0);
    run_phase(256, 1, 140, 1'b0);
    run_phase(1, 256, 140, 1'b0);
    run_phase(17, 9, 140, 1'b0);
    run_phase(100, 60, 140, 1'b0);
    run_phase(255, 256, 140, 1'b0);
    run_phase(6, 4, 140, 1'b0);
    settle();

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
